[sv/kml_pkg.sv]
`timescale 1ns / 1ps
package kml_pkg;

  localparam int MAX_POINTS_DEF   = 1024;
  localparam int MAX_DIMS_DEF     = 8;
  localparam int MAX_CLUSTERS_DEF = 8;
  localparam int COORD_BITS       = 16;

  typedef enum logic [2:0] {
    OP_LOAD_POINT  = 3'd0,
    OP_LOAD_CENTRE = 3'd1,
    OP_START       = 3'd2,
    OP_READ_LABEL  = 3'd3,
    OP_READ_CENTRE = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    KIND_DONE   = 2'd0,
    KIND_LABEL  = 2'd1,
    KIND_CENTRE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CFG_DIMS     = 2'd0,
    CFG_CLUSTERS = 2'd1,
    CFG_POINTS   = 2'd2,
    CFG_ROUNDS   = 2'd3
  } cfg_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLR_LBL,
    ST_CLR_SUM,
    ST_D_RD,
    ST_D_MUL,
    ST_D_ACC,
    ST_D_CMP,
    ST_L_RD,
    ST_L_CHK,
    ST_S_RD,
    ST_S_WR,
    ST_U_CHK,
    ST_U_RD,
    ST_U_DIV,
    ST_U_WAIT,
    ST_R_END,
    ST_FIN
  } state_e;

endpackage

[sv/kmeans_lloyd_clustering_top.sv]
`timescale 1ns / 1ps
// Loads and reads are taken one per cycle while idle; a read result appears the next cycle.
// A start request clears the label store, then runs rounds until no label changes or the
// round limit is reached; round length is set by the shared multiplier, the serial divider
// and the stores, which have one read port and one write port.
// busy is high for the whole run; every result is strobed for one cycle and cannot be stalled.
// Reset clears control state and loads register defaults; labels read as zero until a start.
module kmeans_lloyd_clustering_top
  import kml_pkg::*;
#(
  parameter int MAX_POINTS   = kml_pkg::MAX_POINTS_DEF,
  parameter int MAX_DIMS     = kml_pkg::MAX_DIMS_DEF,
  parameter int MAX_CLUSTERS = kml_pkg::MAX_CLUSTERS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic [2:0]  operation_i,
  input  logic [9:0]  item_index_i,
  input  logic [2:0]  coord_index_i,
  input  logic signed [15:0] coord_value_i,
  output logic        result_valid_o,
  output logic [1:0]  result_kind_o,
  output logic [2:0]  cluster_label_o,
  output logic signed [15:0] centre_value_o,
  output logic [15:0] rounds_run_o,
  output logic        converged_o
);

  localparam int PW  = $clog2(MAX_POINTS);
  localparam int DW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CW  = $clog2(MAX_CLUSTERS);
  localparam int CNW = PW + 1;
  localparam int SW  = COORD_BITS + PW;
  localparam int QW  = 2 * COORD_BITS + 2;
  localparam int AW  = QW + DW;
  localparam int PT_DEPTH = MAX_POINTS * (2 ** DW);
  localparam int SM_DEPTH = MAX_CLUSTERS * (2 ** DW);

  state_e state_q, state_d;

  logic [3:0]  dims_q, clus_q;
  logic [10:0] pts_q;
  logic [15:0] maxr_q;

  logic [PW-1:0]  p_q, p_d;
  logic [CW-1:0]  c_q, c_d, bestc_q, bestc_d;
  logic [DW-1:0]  j_q, j_d;
  logic [AW-1:0]  acc_q, acc_d, best_q, best_d;
  logic [QW-1:0]  sq_q, sq_d;
  logic           changed_q, changed_d, conv_q, conv_d, done_q, done_d;
  logic [15:0]    round_q, round_d, lim_q, lim_d;
  logic [DW:0]    d_q, d_d;
  logic [CW:0]    k_q, k_d;
  logic [PW:0]    n_q, n_d;
  logic [CNW-1:0] cnt_q [MAX_CLUSTERS];
  logic [CNW-1:0] cnt_d [MAX_CLUSTERS];
  logic           rd_pend_q, rd_pend_d, rd_ok_q, rd_ok_d;
  logic           lb_init_q, lb_init_d;
  kind_e          rd_kind_q, rd_kind_d;

  logic                  pt_we;
  logic [PW+DW-1:0]      pt_waddr, pt_raddr;
  logic signed [15:0]    pt_rdata;
  logic                  ce_we;
  logic [CW+DW-1:0]      ce_waddr, ce_raddr;
  logic [15:0]           ce_wdata;
  logic signed [15:0]    ce_rdata;
  logic                  lb_we;
  logic [PW-1:0]         lb_waddr, lb_raddr;
  logic [CW-1:0]         lb_wdata, lb_rdata;
  logic                  sm_we;
  logic [CW+DW-1:0]      sm_waddr, sm_raddr;
  logic [SW-1:0]         sm_wdata, sm_rdata;
  logic                  div_start, div_done;
  logic signed [SW-1:0]  div_q;

  logic                  accept, pt_ok, cd_ok, lb_ok, j_last, c_last, p_last;
  logic [CW-1:0]         cidx;
  logic signed [COORD_BITS:0] diff;
  logic signed [QW-1:0]  prod;

  kml_ram #(.WIDTH(16), .DEPTH(PT_DEPTH)) u_pt_ram (
    .clk_i, .we_i(pt_we), .waddr_i(pt_waddr), .wdata_i(coord_value_i),
    .raddr_i(pt_raddr), .rdata_o(pt_rdata)
  );
  kml_ram #(.WIDTH(16), .DEPTH(SM_DEPTH)) u_ce_ram (
    .clk_i, .we_i(ce_we), .waddr_i(ce_waddr), .wdata_i(ce_wdata),
    .raddr_i(ce_raddr), .rdata_o(ce_rdata)
  );
  kml_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_lb_ram (
    .clk_i, .we_i(lb_we), .waddr_i(lb_waddr), .wdata_i(lb_wdata),
    .raddr_i(lb_raddr), .rdata_o(lb_rdata)
  );
  kml_ram #(.WIDTH(SW), .DEPTH(SM_DEPTH)) u_sm_ram (
    .clk_i, .we_i(sm_we), .waddr_i(sm_waddr), .wdata_i(sm_wdata),
    .raddr_i(sm_raddr), .rdata_o(sm_rdata)
  );
  kml_div #(.DVD_W(SW), .DVS_W(CNW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(signed'(sm_rdata)),
    .divisor_i(cnt_q[c_q]), .done_o(div_done), .quotient_o(div_q)
  );

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign pt_ok  = (32'(item_index_i) < MAX_POINTS) && (32'(coord_index_i) < MAX_DIMS);
  assign cd_ok  = (32'(coord_index_i) < MAX_DIMS);
  assign lb_ok  = (32'(item_index_i) < MAX_POINTS);
  assign cidx   = CW'(32'(item_index_i) % MAX_CLUSTERS);
  assign j_last = ({1'b0, j_q} == d_q - (DW + 1)'(1));
  assign c_last = ({1'b0, c_q} == k_q - (CW + 1)'(1));
  assign p_last = ({1'b0, p_q} == n_q - (PW + 1)'(1));
  assign diff   = {pt_rdata[15], pt_rdata} - {ce_rdata[15], ce_rdata};
  assign prod   = diff * diff;

  always_comb begin
    state_d   = state_q;
    p_d       = p_q;
    c_d       = c_q;
    j_d       = j_q;
    acc_d     = acc_q;
    best_d    = best_q;
    bestc_d   = bestc_q;
    sq_d      = sq_q;
    changed_d = changed_q;
    conv_d    = conv_q;
    done_d    = 1'b0;
    round_d   = round_q;
    lim_d     = lim_q;
    d_d       = d_q;
    k_d       = k_q;
    n_d       = n_q;
    cnt_d     = cnt_q;
    rd_pend_d = 1'b0;
    rd_ok_d   = rd_ok_q;
    rd_kind_d = rd_kind_q;
    lb_init_d = lb_init_q;
    pt_we     = 1'b0;
    pt_waddr  = {PW'(item_index_i), DW'(coord_index_i)};
    pt_raddr  = {p_q, j_q};
    ce_we     = 1'b0;
    ce_waddr  = {cidx, DW'(coord_index_i)};
    ce_wdata  = coord_value_i;
    ce_raddr  = {c_q, j_q};
    lb_we     = 1'b0;
    lb_waddr  = p_q;
    lb_wdata  = bestc_q;
    lb_raddr  = p_q;
    sm_we     = 1'b0;
    sm_waddr  = {bestc_q, j_q};
    sm_wdata  = sm_rdata + SW'(pt_rdata);
    sm_raddr  = {bestc_q, j_q};
    div_start = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        lb_raddr = PW'(item_index_i);
        ce_raddr = {cidx, DW'(coord_index_i)};
        if (accept) begin
          case (operation_i)
            OP_LOAD_POINT: pt_we = pt_ok;
            OP_LOAD_CENTRE: ce_we = cd_ok;
            OP_START: begin
              d_d = (dims_q == 4'd0) ? (DW + 1)'(1) :
                    (32'(dims_q) > MAX_DIMS) ? (DW + 1)'(MAX_DIMS) : (DW + 1)'(dims_q);
              k_d = (clus_q == 4'd0) ? (CW + 1)'(1) :
                    (32'(clus_q) > MAX_CLUSTERS) ? (CW + 1)'(MAX_CLUSTERS) :
                    (CW + 1)'(clus_q);
              n_d = (pts_q == 11'd0) ? (PW + 1)'(1) :
                    (32'(pts_q) > MAX_POINTS) ? (PW + 1)'(MAX_POINTS) : (PW + 1)'(pts_q);
              lim_d     = (maxr_q == 16'd0) ? 16'd1 : maxr_q;
              round_d   = '0;
              p_d       = '0;
              lb_init_d = 1'b1;
              state_d   = ST_CLR_LBL;
            end
            OP_READ_LABEL: begin
              rd_pend_d = 1'b1;
              rd_kind_d = KIND_LABEL;
              rd_ok_d   = lb_ok;
            end
            OP_READ_CENTRE: begin
              rd_pend_d = 1'b1;
              rd_kind_d = KIND_CENTRE;
              rd_ok_d   = cd_ok;
            end
            default: ;
          endcase
        end
      end
      ST_CLR_LBL: begin
        lb_we    = 1'b1;
        lb_wdata = '0;
        p_d      = p_q + PW'(1);
        if (p_q == PW'(MAX_POINTS - 1)) begin
          c_d     = '0;
          j_d     = '0;
          round_d = round_q + 16'd1;
          state_d = ST_CLR_SUM;
        end
      end
      ST_CLR_SUM: begin
        sm_we    = 1'b1;
        sm_waddr = {c_q, j_q};
        sm_wdata = '0;
        {c_d, j_d} = {c_q, j_q} + (CW + DW)'(1);
        if (&{c_q, j_q}) begin
          for (int i = 0; i < MAX_CLUSTERS; i++) begin
            cnt_d[i] = '0;
          end
          changed_d = 1'b0;
          p_d       = '0;
          c_d       = '0;
          j_d       = '0;
          acc_d     = '0;
          state_d   = ST_D_RD;
        end
      end
      ST_D_RD: state_d = ST_D_MUL;
      ST_D_MUL: begin
        sq_d    = QW'(unsigned'(prod));
        state_d = ST_D_ACC;
      end
      ST_D_ACC: begin
        acc_d = acc_q + AW'(sq_q);
        if (j_last) begin
          state_d = ST_D_CMP;
        end else begin
          j_d     = j_q + DW'(1);
          state_d = ST_D_RD;
        end
      end
      ST_D_CMP: begin
        if (c_q == '0 || acc_q < best_q) begin
          best_d  = acc_q;
          bestc_d = c_q;
        end
        j_d   = '0;
        acc_d = '0;
        if (c_last) begin
          state_d = ST_L_RD;
        end else begin
          c_d     = c_q + CW'(1);
          state_d = ST_D_RD;
        end
      end
      ST_L_RD: state_d = ST_L_CHK;
      ST_L_CHK: begin
        if (lb_rdata != bestc_q) begin
          changed_d = 1'b1;
        end
        lb_we          = 1'b1;
        cnt_d[bestc_q] = cnt_q[bestc_q] + CNW'(1);
        j_d            = '0;
        state_d        = ST_S_RD;
      end
      ST_S_RD: state_d = ST_S_WR;
      ST_S_WR: begin
        sm_we = 1'b1;
        if (j_last) begin
          j_d = '0;
          c_d = '0;
          if (p_last) begin
            state_d = ST_U_CHK;
          end else begin
            p_d     = p_q + PW'(1);
            acc_d   = '0;
            state_d = ST_D_RD;
          end
        end else begin
          j_d     = j_q + DW'(1);
          state_d = ST_S_RD;
        end
      end
      ST_U_CHK: begin
        j_d = '0;
        if (cnt_q[c_q] != '0) begin
          state_d = ST_U_RD;
        end else if (c_last) begin
          state_d = ST_R_END;
        end else begin
          c_d = c_q + CW'(1);
        end
      end
      ST_U_RD: begin
        sm_raddr = {c_q, j_q};
        state_d  = ST_U_DIV;
      end
      ST_U_DIV: begin
        div_start = 1'b1;
        state_d   = ST_U_WAIT;
      end
      ST_U_WAIT: begin
        if (div_done) begin
          ce_we    = 1'b1;
          ce_waddr = {c_q, j_q};
          ce_wdata = div_q[15:0];
          if (j_last) begin
            j_d = '0;
            if (c_last) begin
              state_d = ST_R_END;
            end else begin
              c_d     = c_q + CW'(1);
              state_d = ST_U_CHK;
            end
          end else begin
            j_d     = j_q + DW'(1);
            state_d = ST_U_RD;
          end
        end
      end
      ST_R_END: begin
        c_d = '0;
        j_d = '0;
        if (!changed_q) begin
          conv_d  = 1'b1;
          state_d = ST_FIN;
        end else if (round_q >= lim_q) begin
          conv_d  = 1'b0;
          state_d = ST_FIN;
        end else begin
          round_d = round_q + 16'd1;
          state_d = ST_CLR_SUM;
        end
      end
      ST_FIN: begin
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      dims_q    <= 4'd2;
      clus_q    <= 4'd3;
      pts_q     <= 11'd1;
      maxr_q    <= 16'd100;
      done_q    <= 1'b0;
      rd_pend_q <= 1'b0;
      lb_init_q <= 1'b0;
      round_q   <= '0;
      conv_q    <= 1'b0;
      p_q       <= '0;
      c_q       <= '0;
      j_q       <= '0;
    end else begin
      state_q   <= state_d;
      done_q    <= done_d;
      rd_pend_q <= rd_pend_d;
      lb_init_q <= lb_init_d;
      round_q   <= round_d;
      conv_q    <= conv_d;
      p_q       <= p_d;
      c_q       <= c_d;
      j_q       <= j_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_DIMS:     dims_q <= cfg_data_i[3:0];
          CFG_CLUSTERS: clus_q <= cfg_data_i[3:0];
          CFG_POINTS:   pts_q  <= cfg_data_i[10:0];
          CFG_ROUNDS:   maxr_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q     <= acc_d;
    best_q    <= best_d;
    bestc_q   <= bestc_d;
    sq_q      <= sq_d;
    changed_q <= changed_d;
    lim_q     <= lim_d;
    d_q       <= d_d;
    k_q       <= k_d;
    n_q       <= n_d;
    cnt_q     <= cnt_d;
    rd_ok_q   <= rd_ok_d;
    rd_kind_q <= rd_kind_d;
  end

  assign result_valid_o  = rd_pend_q | done_q;
  assign result_kind_o   = done_q ? KIND_DONE : rd_kind_q;
  assign cluster_label_o = (rd_pend_q && rd_kind_q == KIND_LABEL && rd_ok_q && lb_init_q) ?
                           3'(lb_rdata) : 3'd0;
  assign centre_value_o  = (rd_pend_q && rd_kind_q == KIND_CENTRE && rd_ok_q) ?
                           ce_rdata : 16'sd0;
  assign rounds_run_o    = done_q ? round_q : 16'd0;
  assign converged_o     = done_q & conv_q;

endmodule

[sv/kml_ram.sv]
`timescale 1ns / 1ps
module kml_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[sv/kml_div.sv]
`timescale 1ns / 1ps
module kml_div #(
  parameter int DVD_W = 26,
  parameter int DVS_W = 11
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0]        divisor_i,
  output logic                    done_o,
  output logic signed [DVD_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] mag_q, mag_d;
  logic [DVS_W:0]   rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             neg_q, neg_d;
  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [DVS_W:0]   rem_sh;

  always_comb begin
    mag_d  = mag_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    run_d  = run_q;
    done_d = 1'b0;
    rem_sh = {rem_q[DVS_W-1:0], mag_q[DVD_W-1]};
    if (start_i) begin
      neg_d = dividend_i[DVD_W-1];
      mag_d = dividend_i[DVD_W-1] ? DVD_W'(-dividend_i) : DVD_W'(dividend_i);
      rem_d = '0;
      dvs_d = divisor_i;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = rem_sh - {1'b0, dvs_q};
        mag_d = {mag_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        mag_d = {mag_q[DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DVD_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -signed'(mag_q) : signed'(mag_q);

endmodule
